FILE: hdl/eeg_adc_frame_deframer_defines.svh
// assertion macros shared by the deframer rtl
`ifndef EEG_ADC_FRAME_DEFRAMER_DEFINES_SVH
`define EEG_ADC_FRAME_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
`define EAFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("deframer assertion failed");
`define EAFD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("deframer forbidden condition seen");
`else
`define EAFD_ASSERT(lbl, clk, rstn, prop)
`define EAFD_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: hdl/eafd_pkg.sv
// types and constants of the adc frame deframer
package eafd_pkg;

  localparam int unsigned CHIP_W    = 2;
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned FIELD_W   = 4;
  localparam int unsigned WORD_W    = 24;
  localparam int unsigned PART_W    = 16;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [KIND_W-1:0] {
    KIND_TIMESTAMP = 3'd0,
    KIND_EVENT     = 3'd1,
    KIND_STATUS    = 3'd2,
    KIND_SAMPLE    = 3'd3,
    KIND_LEN_ERR   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic [CHIP_W-1:0]         chip;
    logic [CHAN_W-1:0]         chan;
    logic [WORD_W-1:0]         raw;
    logic signed [WORD_W-1:0]  sample;
    logic                      last;
  } res_t;

endpackage

FILE: hdl/eafd_tracker.sv
// frame position counters, field assembly and result decode
`include "eeg_adc_frame_deframer_defines.svh"

module eafd_tracker #(
  parameter int unsigned CHIP_COUNT        = 4,
  parameter int unsigned CHANNELS_PER_CHIP = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             take_i,
  input  logic [eafd_pkg::IN_DATA_W-1:0]   byte_i,
  input  logic                             pend_i,
  output logic                             res_valid_o,
  output eafd_pkg::res_t                   res_o
);

  localparam logic [eafd_pkg::FIELD_W-1:0] LastField =
    eafd_pkg::FIELD_W'(CHANNELS_PER_CHIP);
  localparam logic [eafd_pkg::CHIP_W-1:0] LastChip =
    eafd_pkg::CHIP_W'(CHIP_COUNT - 1);

  logic                           body_q, body_d;
  logic [1:0]                     hdr_q, hdr_d;
  logic [1:0]                     byte_q, byte_d;
  logic [eafd_pkg::FIELD_W-1:0]   field_q, field_d;
  logic [eafd_pkg::CHIP_W-1:0]    chip_q, chip_d;
  logic [eafd_pkg::PART_W-1:0]    pw_q, pw_d;
  logic                           last_byte;
  logic [eafd_pkg::WORD_W-1:0]    word;
  logic                           field_done;

  assign last_byte = body_q && (byte_q == 2'd2) && (field_q == LastField)
                     && (chip_q == LastChip);
  assign word = {pw_q, byte_i};

  always_comb begin
    body_d     = body_q;
    hdr_d      = hdr_q;
    byte_d     = byte_q;
    field_d    = field_q;
    chip_d     = chip_q;
    pw_d       = pw_q;
    field_done = 1'b0;
    res_o      = '0;
    res_o.kind = eafd_pkg::KIND_TIMESTAMP;

    if (!body_q) begin
      // header: little-endian timestamp then event byte
      case (hdr_q)
        2'd0: begin
          pw_d = {8'h00, byte_i};
        end
        2'd1: begin
          pw_d = {byte_i, pw_q[7:0]};
        end
        2'd2: begin
          field_done = 1'b1;
          res_o.kind = eafd_pkg::KIND_TIMESTAMP;
          res_o.raw  = {byte_i, pw_q};
        end
        default: begin
          field_done = 1'b1;
          res_o.kind = eafd_pkg::KIND_EVENT;
          res_o.raw  = {16'h0000, byte_i};
        end
      endcase
      if (hdr_q == 2'd3) begin
        body_d  = 1'b1;
        hdr_d   = 2'd0;
        byte_d  = 2'd0;
        field_d = '0;
        chip_d  = '0;
      end else begin
        hdr_d = hdr_q + 2'd1;
      end
    end else begin
      // chip block: big-endian status word then samples
      case (byte_q)
        2'd0: begin
          pw_d = {8'h00, byte_i};
        end
        2'd1: begin
          pw_d = {pw_q[7:0], byte_i};
        end
        default: begin
          field_done = 1'b1;
          res_o.chip = chip_q;
          if (field_q == '0) begin
            res_o.kind = eafd_pkg::KIND_STATUS;
            res_o.raw  = word;
          end else begin
            res_o.kind   = eafd_pkg::KIND_SAMPLE;
            res_o.chan   = eafd_pkg::CHAN_W'(field_q - 4'd1);
            res_o.sample = word;
            res_o.last   = last_byte;
          end
        end
      endcase
      if (byte_q == 2'd2) begin
        byte_d = 2'd0;
        if (field_q == LastField) begin
          field_d = '0;
          if (chip_q == LastChip) begin
            body_d = 1'b0;
            hdr_d  = 2'd0;
            chip_d = '0;
          end else begin
            chip_d = chip_q + 1'b1;
          end
        end else begin
          field_d = field_q + 1'b1;
        end
      end else begin
        byte_d = byte_q + 2'd1;
      end
    end

    // packet ended mid frame: single error word, framing restarts
    if (pend_i && !last_byte) begin
      res_o      = '0;
      res_o.kind = eafd_pkg::KIND_LEN_ERR;
      body_d     = 1'b0;
      hdr_d      = 2'd0;
      byte_d     = 2'd0;
      field_d    = '0;
      chip_d     = '0;
    end
  end

  assign res_valid_o = field_done || (pend_i && !last_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_q  <= 1'b0;
      hdr_q   <= 2'd0;
      byte_q  <= 2'd0;
      field_q <= '0;
      chip_q  <= '0;
    end else if (take_i) begin
      body_q  <= body_d;
      hdr_q   <= hdr_d;
      byte_q  <= byte_d;
      field_q <= field_d;
      chip_q  <= chip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      pw_q <= pw_d;
    end
  end

  `EAFD_ASSERT(a_err_restarts, clk_i, rst_ni, (take_i && res_valid_o && res_o.kind == eafd_pkg::KIND_LEN_ERR) |=> (!body_q && hdr_q == 2'd0))
  `EAFD_ASSERT(a_last_is_final_sample, clk_i, rst_ni, (res_valid_o && res_o.last) |-> (res_o.kind == eafd_pkg::KIND_SAMPLE && res_o.chip == LastChip && res_o.chan == eafd_pkg::CHAN_W'(CHANNELS_PER_CHIP - 1)))
  `EAFD_ASSERT(a_body_in_range, clk_i, rst_ni, body_q |-> (field_q <= LastField && chip_q <= LastChip && byte_q != 2'd3))
  `EAFD_ASSERT_NEVER(a_hdr_idle_in_body, clk_i, rst_ni, body_q && hdr_q != 2'd0)

endmodule

FILE: hdl/eafd_out_reg.sv
// result register toward the output stream
module eafd_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  eafd_pkg::res_t  res_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            take_i,
  output eafd_pkg::res_t  res_o
);

  logic           valid_q, valid_d;
  eafd_pkg::res_t res_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: hdl/eeg_adc_frame_deframer.sv
// top level of the multi-chip adc byte-stream deframer
//
// channel   dir  tdata                           tuser       tlast
// s_axis    in   [7:0] data byte                 -           packet end
// m_axis    out  chip, channel, raw, sample      [2:0] kind  last sample of frame
//
// one byte accepted per clock while m_axis does not stall; results pass the input register, then the result register
// the input register and the result register each advance at most once per cycle
// rst_ni clears framing to the start of a frame and empties both registers
// a stall on m_axis holds the result register; the input register keeps taking
// bytes whose decode yields no word until a word-producing byte must wait
`include "eeg_adc_frame_deframer_defines.svh"

module eeg_adc_frame_deframer #(
  parameter int unsigned CHIP_COUNT        = 4,
  parameter int unsigned CHANNELS_PER_CHIP = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input byte stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [eafd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
  input  logic                               s_axis_tlast,  // packet_end
  // decoded field words
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] chip_index, [4:2] channel_index, [28:5] raw_word,
  // [52:29] sample_value, [55:53] zero
  output logic [eafd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [eafd_pkg::KIND_W-1:0]        m_axis_tuser,  // [2:0] kind
  output logic                               m_axis_tlast   // frame_last
);

  // input register
  logic                              in_valid_q, in_valid_d;
  logic [eafd_pkg::IN_DATA_W-1:0]    in_byte_q;
  logic                              in_pend_q;

  logic           res_valid;
  eafd_pkg::res_t res;
  logic           out_ready;
  logic           advance;
  eafd_pkg::res_t out_res;

  // the held byte moves on when it makes no word or the result slot is free
  assign advance       = in_valid_q && (!res_valid || out_ready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_pend_q <= s_axis_tlast;
    end
  end

  // framing state and field decode
  eafd_tracker #(
    .CHIP_COUNT        (CHIP_COUNT),
    .CHANNELS_PER_CHIP (CHANNELS_PER_CHIP)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (advance),
    .byte_i      (in_byte_q),
    .pend_i      (in_pend_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  eafd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .res_i   (res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.sample, out_res.raw, out_res.chan, out_res.chip};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
